@@ rtl/fmosc_pkg.sv @@
// ----------------------------------------------------------------------------
// fmosc_pkg
// Shared types, constants and the sine table generator for the two-operator
// FM oscillator.
// ----------------------------------------------------------------------------
package fmosc_pkg;

  // Default sizes
  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned TABLE_ADDR_BITS_DEF = 8;
  localparam int unsigned SAMPLE_BITS_DEF     = 16;

  // Fixed port widths
  localparam int unsigned BASE_BITS  = 31;
  localparam int unsigned RATIO_BITS = 16;
  localparam int unsigned OUT_BITS   = 16;

  // Deviation magnitude is clamped to 2^40
  localparam int unsigned  DEV_BITS  = 41;
  localparam logic [40:0]  DEV_CLAMP = 41'h100_0000_0000;

  // Width of the signed step before saturation
  localparam int unsigned STEP_BITS = 43;

  // Accumulator memory entries
  localparam logic ACC_MOD = 1'b0;
  localparam logic ACC_CAR = 1'b1;

  // pi/2 in Q30 and the Taylor divisors (2n)(2n+1) for n = 1..8
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD_RD,
    S_MOD_MUL,
    S_CAR_MUL,
    S_DEV0,
    S_DEV1,
    S_DEV2,
    S_DEV3,
    S_STEP
  } fmosc_state_t;

  // sin(pi/2 * r / 2^qbits) in Q30, truncated Taylor terms
  function automatic longint quarter_sine_q30(longint unsigned r, int unsigned qbits);
    longint unsigned x;
    longint unsigned t;
    longint          s;
    x = (PI_HALF_Q30 * r) >> qbits;
    t = x;
    s = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / TAYLOR_DIV[n-1];
      if (n[0]) begin
        s = s - longint'(t);
      end else begin
        s = s + longint'(t);
      end
    end
    return s;
  endfunction

  // Quarter-wave entry in Q1.(sb-1), rounded half up, peak clamped
  function automatic longint quarter_entry(longint unsigned r, int unsigned qbits,
                                           int unsigned sb);
    longint s;
    longint v;
    longint maxv;
    s    = quarter_sine_q30(r, qbits);
    maxv = (longint'(1) << (sb - 1)) - 1;
    if (s < 0) begin
      s = 0;
    end
    v = ((s << (sb - 1)) + (longint'(1) << 29)) >>> 30;
    if (v > maxv) begin
      v = maxv;
    end
    return v;
  endfunction

  // Full-wave table entry k of a 2^tab_bits entry table
  function automatic logic signed [31:0] sine_entry(int unsigned k, int unsigned tab_bits,
                                                    int unsigned sb);
    int unsigned quad;
    int unsigned r;
    int unsigned qbits;
    longint      v;
    qbits = tab_bits - 2;
    quad  = k >> qbits;
    r     = k & ((32'd1 << qbits) - 1);
    if (quad[0]) begin
      v = quarter_entry(longint'((32'd1 << qbits) - r), qbits, sb);
    end else begin
      v = quarter_entry(longint'(r), qbits, sb);
    end
    if (quad[1]) begin
      v = -v;
    end
    return 32'(v);
  endfunction

endpackage

@@ rtl/two_operator_fm_oscillator.sv @@
// ----------------------------------------------------------------------------
// two_operator_fm_oscillator
// Two-operator FM sine oscillator: one request in, one carrier sample out.
// ----------------------------------------------------------------------------
// Each request (base_step, harmonicity, mod_index) produces one Q1.15 carrier
// sample. A request is taken in S_IDLE and then runs eight sequencer
// steps, set by the single read port of the two-entry accumulator
// memory, the shared interpolation multiplier (modulator, then carrier) and
// the four-step deviation product chain. req_stall is high during those
// steps, and longer if a finished sample still waits on smp_stall when the
// next one is ready. The result sits in an output register, so the next
// request is taken while a sample waits to be read. Both phase accumulators
// reset to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module two_operator_fm_oscillator #(
  parameter int unsigned PHASE_BITS      = fmosc_pkg::PHASE_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = fmosc_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = fmosc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  logic [fmosc_pkg::BASE_BITS-1:0]        base_step,
  input  logic [fmosc_pkg::RATIO_BITS-1:0]       harmonicity,
  input  logic [fmosc_pkg::RATIO_BITS-1:0]       mod_index,
  output logic                                   smp_valid,
  input  logic                                   smp_stall,
  output logic signed [fmosc_pkg::OUT_BITS-1:0]  sample
);

  localparam int unsigned PB    = PHASE_BITS;
  localparam int unsigned TAB   = TABLE_ADDR_BITS;
  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned TSIZE = 1 << TAB;
  localparam int unsigned FB    = PB - TAB;
  localparam int unsigned IPW   = SB + FB + 2;
  localparam int unsigned BB    = fmosc_pkg::BASE_BITS;
  localparam int unsigned RB    = fmosc_pkg::RATIO_BITS;
  localparam int unsigned MSW   = BB + RB;
  localparam int unsigned PW    = SB + 64;
  localparam int unsigned SH    = SB + 14;
  localparam int unsigned DFW   = PW - SH;
  localparam int unsigned DB    = fmosc_pkg::DEV_BITS;
  localparam int unsigned STW   = fmosc_pkg::STEP_BITS;
  localparam int unsigned OB    = fmosc_pkg::OUT_BITS;

  localparam logic signed [IPW-1:0] IP_HALF  = IPW'(1) <<< (FB - 1);
  localparam logic signed [STW-1:0] STEP_MAX = (STW'(1) <<< (PB - 1)) - STW'(1);
  localparam logic signed [STW-1:0] STEP_MIN = -(STW'(1) <<< (PB - 1));

  // Sine table, built at elaboration
  logic signed [SB-1:0] rom_tab [TSIZE];
  for (genvar k = 0; k < TSIZE; k++) begin : g_rom
    assign rom_tab[k] = SB'(fmosc_pkg::sine_entry(k, TAB, SB));
  end

  // Sequencer and control
  fmosc_pkg::fmosc_state_t state, state_next;
  logic          slot_free;
  logic          req_take;
  logic          rd_addr;
  logic          mem_wr_en;
  logic          mem_wr_addr;
  logic [PB-1:0] mem_wr_data;
  logic          out_load;

  // Accumulator memory with per-entry valid bits
  logic [PB-1:0] acc_mem [2];
  logic [1:0]    acc_vld;
  logic [PB-1:0] mem_q;
  logic          mem_vq;
  logic [PB-1:0] acc_rd;

  // Request and datapath registers
  logic [BB-1:0]         b_q;
  logic [RB-1:0]         h_q;
  logic [RB-1:0]         ix_q;
  logic [PB-1:0]         mstep_q;
  logic [PB-1:0]         car_q;
  logic signed [SB-1:0]  rom_y;
  logic signed [SB-1:0]  rom_y1;
  logic [FB-1:0]         frac_q;
  logic signed [IPW-1:0] ip_prod;
  logic signed [SB-1:0]  ip_base;
  logic signed [SB-1:0]  m_q;
  logic signed [SB-1:0]  c_q;
  logic                  m_neg_q;
  logic [SB+RB-1:0]      mh_q;
  logic [SB+2*RB-1:0]    mag_q;
  logic [62:0]           pp_lo_q;
  logic [SB+BB-1:0]      pp_hi_q;
  logic [DB-1:0]         dev_q;

  // Combinational datapath
  logic [MSW-1:0]        mstep_full;
  logic [TAB-1:0]        top;
  logic [TAB-1:0]        top1;
  logic signed [SB:0]    ip_diff;
  logic signed [FB:0]    ip_frac;
  logic signed [IPW-1:0] ip_mul;
  logic signed [IPW-1:0] ip_sum;
  logic signed [SB-1:0]  ip_res;
  logic [SB-1:0]         m_abs;
  logic [PW-1:0]         dev_sum;
  logic [DFW-1:0]        dev_full;
  logic signed [STW-1:0] step_b;
  logic signed [STW-1:0] step_d;
  logic signed [STW-1:0] step_raw;
  logic [PB-1:0]         step_sat;
  logic [PB-1:0]         car_new;
  logic signed [OB-1:0]  out_val;

  assign slot_free = !smp_valid || !smp_stall;
  assign req_take  = req_valid && !req_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fmosc_pkg::S_IDLE:    if (req_valid) state_next = fmosc_pkg::S_MOD_RD;
      fmosc_pkg::S_MOD_RD:  state_next = fmosc_pkg::S_MOD_MUL;
      fmosc_pkg::S_MOD_MUL: state_next = fmosc_pkg::S_CAR_MUL;
      fmosc_pkg::S_CAR_MUL: state_next = fmosc_pkg::S_DEV0;
      fmosc_pkg::S_DEV0:    state_next = fmosc_pkg::S_DEV1;
      fmosc_pkg::S_DEV1:    state_next = fmosc_pkg::S_DEV2;
      fmosc_pkg::S_DEV2:    state_next = fmosc_pkg::S_DEV3;
      fmosc_pkg::S_DEV3:    state_next = fmosc_pkg::S_STEP;
      fmosc_pkg::S_STEP:    if (slot_free) state_next = fmosc_pkg::S_IDLE;
      default:              state_next = fmosc_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    req_stall   = 1'b1;
    rd_addr     = fmosc_pkg::ACC_CAR;
    mem_wr_en   = 1'b0;
    mem_wr_addr = fmosc_pkg::ACC_CAR;
    mem_wr_data = car_new;
    out_load    = 1'b0;
    unique case (state)
      fmosc_pkg::S_IDLE: begin
        req_stall = 1'b0;
        rd_addr   = fmosc_pkg::ACC_MOD;
      end
      fmosc_pkg::S_MOD_RD: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = fmosc_pkg::ACC_MOD;
        mem_wr_data = acc_rd + mstep_q;
      end
      fmosc_pkg::S_STEP: begin
        mem_wr_en = slot_free;
        out_load  = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmosc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accumulator memory: read every cycle, write back once per operator.
  // The modulator entry is written in S_MOD_RD while the carrier entry is
  // read, and the carrier entry is written long before the next read of
  // it, so no forwarding is needed.
  always_ff @(posedge clk) begin
    mem_q  <= acc_mem[rd_addr];
    mem_vq <= acc_vld[rd_addr];
    if (mem_wr_en) begin
      acc_mem[mem_wr_addr] <= mem_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
    end else if (mem_wr_en) begin
      acc_vld[mem_wr_addr] <= 1'b1;
    end
  end

  assign acc_rd = mem_vq ? mem_q : '0;

  // Modulator step from the request
  assign mstep_full = MSW'(base_step) * MSW'(harmonicity);

  // Table addresses and fraction of the accumulator just read
  assign top  = acc_rd[PB-1 -: TAB];
  assign top1 = top + TAB'(1);

  // Shared linear interpolation
  assign ip_diff = (SB+1)'(rom_y1) - (SB+1)'(rom_y);
  assign ip_frac = $signed({1'b0, frac_q});
  assign ip_mul  = IPW'(ip_diff) * IPW'(ip_frac) + IP_HALF;
  assign ip_sum  = IPW'(ip_base) + (ip_prod >>> FB);
  assign ip_res  = ip_sum[SB-1:0];

  // Deviation and carrier step
  assign m_abs    = m_q[SB-1] ? SB'(-m_q) : SB'(m_q);
  assign dev_sum  = PW'({pp_hi_q, 32'b0}) + PW'(pp_lo_q);
  assign dev_full = dev_sum[PW-1:SH];
  assign step_b   = $signed(STW'(b_q));
  assign step_d   = $signed(STW'(dev_q));
  assign step_raw = m_neg_q ? (step_b - step_d) : (step_b + step_d);

  always_comb begin
    priority if (step_raw > STEP_MAX) begin
      step_sat = STEP_MAX[PB-1:0];
    end else if (step_raw < STEP_MIN) begin
      step_sat = STEP_MIN[PB-1:0];
    end else begin
      step_sat = step_raw[PB-1:0];
    end
  end

  assign car_new = car_q + step_sat;

  // Align the carrier sample to the output width
  if (SB > OB) begin : g_out_trunc
    assign out_val = c_q[SB-1 -: OB];
  end else if (SB < OB) begin : g_out_ext
    assign out_val = {c_q, {(OB-SB){1'b0}}};
  end else begin : g_out_same
    assign out_val = OB'(c_q);
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (req_take) begin
      b_q     <= base_step;
      h_q     <= harmonicity;
      ix_q    <= mod_index;
      mstep_q <= mstep_full[8 +: PB];
    end
    // Fetch table pair: modulator, then carrier
    if (state == fmosc_pkg::S_MOD_RD || state == fmosc_pkg::S_MOD_MUL) begin
      rom_y  <= rom_tab[top];
      rom_y1 <= rom_tab[top1];
      frac_q <= acc_rd[FB-1:0];
    end
    if (state == fmosc_pkg::S_MOD_MUL) begin
      car_q <= acc_rd;
    end
    // Interpolation multiply: modulator, then carrier
    if (state == fmosc_pkg::S_MOD_MUL || state == fmosc_pkg::S_CAR_MUL) begin
      ip_prod <= ip_mul;
      ip_base <= rom_y;
    end
    if (state == fmosc_pkg::S_CAR_MUL) begin
      m_q <= ip_res;
    end
    if (state == fmosc_pkg::S_DEV0) begin
      c_q     <= ip_res;
      m_neg_q <= m_q[SB-1];
      mh_q    <= (SB+RB)'(m_abs) * (SB+RB)'(h_q);
    end
    if (state == fmosc_pkg::S_DEV1) begin
      mag_q <= (SB+2*RB)'(mh_q) * (SB+2*RB)'(ix_q);
    end
    // Split |m|*h*ix*b into two partial products
    if (state == fmosc_pkg::S_DEV2) begin
      pp_lo_q <= 63'(mag_q[31:0]) * 63'(b_q);
      pp_hi_q <= (SB+BB)'(mag_q[SB+2*RB-1:32]) * (SB+BB)'(b_q);
    end
    if (state == fmosc_pkg::S_DEV3) begin
      if (dev_full > DFW'(fmosc_pkg::DEV_CLAMP)) begin
        dev_q <= fmosc_pkg::DEV_CLAMP;
      end else begin
        dev_q <= dev_full[DB-1:0];
      end
    end
    if (out_load) begin
      sample <= out_val;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (out_load) begin
      smp_valid <= 1'b1;
    end else if (!smp_stall) begin
      smp_valid <= 1'b0;
    end
  end

  // Checks
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> smp_valid)
    else $error("finished sample not presented");

  a_no_wr_on_take: assert property (@(posedge clk) disable iff (rst)
    req_take |-> !mem_wr_en)
    else $error("accumulator write-back overlaps request accept");

  a_wr_owner: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> (state == fmosc_pkg::S_MOD_RD && mem_wr_addr == fmosc_pkg::ACC_MOD) ||
                  (state == fmosc_pkg::S_STEP && mem_wr_addr == fmosc_pkg::ACC_CAR))
    else $error("accumulator write to the wrong entry");

  a_one_write_per_req: assert property (@(posedge clk) disable iff (rst)
    (mem_wr_en && mem_wr_addr == fmosc_pkg::ACC_CAR) |=> state == fmosc_pkg::S_IDLE)
    else $error("carrier write-back did not end the request");

endmodule
